>>> rtl/core/assert_macros.svh
// Assertion helpers for the collider resolver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ACR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`define ACR_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed");
`else
`define ACR_ASSERT_IMPL(label, ante, cons)
`define ACR_ASSERT_NEVER(label, expr)
`endif
`endif

>>> rtl/core/acr_pkg.sv
package acr_pkg;
  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_HORIZ = 2'd1,
    MODE_VERT  = 2'd2,
    MODE_UNSAFE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WALK = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  // Wide enough for x after every push of every pass has piled up.
  localparam int CW = 48;
  localparam logic signed [CW-1:0] STAND_TOL    = CW'(1024);
  localparam logic signed [CW-1:0] SWEEP_MARGIN = CW'(128);

  // One stored collider.
  typedef struct packed {
    logic signed [31:0] left;
    logic signed [31:0] bottom;
    logic [30:0]        width;
    logic [30:0]        height;
    logic signed [31:0] dlo;
    logic signed [31:0] dhi;
    logic               solid;
    logic               unsafe;
  } coll_t;

  // Body query state passed along the chain.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] lo;
    logic signed [CW-1:0] hi;
    logic signed [CW-1:0] z;
    logic signed [CW-1:0] h;
    logic signed [CW-1:0] prev;
    logic                 moved;
    logic                 landed;
    logic                 hit;
  } body_t;
endpackage

>>> rtl/core/acr_cell.sv
module acr_cell (
  input  logic          clk,
  input  logic          wr_en,
  input  acr_pkg::coll_t wr_data,
  input  logic          shift_en,
  input  acr_pkg::coll_t shift_in,
  output acr_pkg::coll_t coll_q
);
  import acr_pkg::*;
  coll_t coll_r;
  always_ff @(posedge clk) begin
    if (wr_en) begin
      coll_r <= wr_data;
    end else if (shift_en) begin
      coll_r <= shift_in;
    end
  end
  assign coll_q = coll_r;
endmodule

>>> rtl/core/acr_eval.sv
module acr_eval (
  input  acr_pkg::mode_t mode,
  input  acr_pkg::coll_t c,
  input  logic          active,
  input  acr_pkg::body_t b,
  output acr_pkg::body_t b_nxt
);
  import acr_pkg::*;
  logic signed [CW-1:0] cl, cb, ctop, cright, top, pl, pr, ptop;
  logic dep;
  always_comb begin
    cl = CW'(c.left);
    cb = CW'(c.bottom);
    ctop = cb + CW'({1'b0, c.height});
    cright = cl + CW'({1'b0, c.width});
    top = b.y + b.h;
    ptop = b.prev + b.h;
    pl = cright - b.lo;
    pr = b.hi - cl;
    dep = !(b.z < CW'(c.dlo) || b.z > CW'(c.dhi));
    b_nxt = b;
    if (active) begin
      case (mode)
        MODE_HORIZ: begin
          if (c.solid && dep && !(b.y >= ctop - STAND_TOL) && !(top <= cb)
              && b.hi > cl && b.lo < cright) begin
            b_nxt.x = (pl < pr) ? b.x - pl : b.x + pr;
            b_nxt.moved = 1'b1;
          end
        end
        MODE_VERT: begin
          if (c.solid && dep && !(b.hi <= cl || b.lo >= cright)) begin
            if (b.prev >= ctop - SWEEP_MARGIN && b.y < ctop) begin
              b_nxt.y = ctop;
              b_nxt.landed = 1'b1;
            end else if (ptop <= cb + SWEEP_MARGIN && top > cb && top < ctop + b.h) begin
              b_nxt.y = cb - b.h;
              b_nxt.landed = 1'b0;
            end
          end
        end
        MODE_UNSAFE: begin
          if (c.unsafe && dep && b.hi > cl && b.lo < cright && b.y < ctop && top > cb)
            b_nxt.hit = 1'b1;
        end
        default: b_nxt = b;
      endcase
    end
  end
endmodule

>>> rtl/core/aabb_collider_table_resolver.sv
// Collider table resolver. Start an item with start while busy is low; the
// result appears for exactly one cycle on out_* with out_valid and cannot be
// held off. The table is a ring of MAX_COLLIDERS storage cells that rotates
// one place per cycle, while a query walks, past a single evaluation unit. A
// write lands in its cell at the accepting edge and its all-zero result
// follows in the next cycle; a new item can be taken once the DONE state has
// returned to idle. A query always walks the full ring whatever collider_count
// is: one rotation for modes 2 and 3, up to PUSH_PASSES rotations for mode 1
// (fewer if a pass moves nothing). The result shows in the cycle after the last
// rotation, and the next item can likewise be taken once DONE returns to idle.
// Table contents are undefined until written; there is no clearing pass.
module aabb_collider_table_resolver #(
  parameter int MAX_COLLIDERS = 64,
  parameter int PUSH_PASSES = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [5:0]  in_slot,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [30:0] in_size_w,
  input  logic [30:0] in_size_h,
  input  logic signed [31:0] in_depth_high,
  input  logic signed [31:0] in_prev_bottom,
  input  logic        in_is_solid,
  input  logic        in_is_unsafe,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_collider_count,
  output logic        out_valid,
  output logic signed [31:0] out_resolved_pos,
  output logic        out_landed,
  output logic        out_unsafe_hit
);
  import acr_pkg::*;
  localparam int IW = $clog2(MAX_COLLIDERS + 1);
  localparam int PW = $clog2(PUSH_PASSES + 1);

  state_t state_r, state_nxt;
  mode_t  mode_r;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [PW-1:0] pass_r, pass_nxt;
  logic [6:0] count_r;
  logic [IW-1:0] active_n;
  body_t body_r, body_nxt, eval_out;
  coll_t cells [MAX_COLLIDERS];
  coll_t wdata;
  logic shift_en, accept;
  logic signed [CW-1:0] res;

  assign accept = start && !busy;
  assign busy = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  // Clamp the count to the table depth.
  assign active_n = (32'(count_r) > 32'(MAX_COLLIDERS)) ? IW'(MAX_COLLIDERS) : IW'(count_r);
  assign wdata = '{left: in_pos_x, bottom: in_pos_y, width: in_size_w, height: in_size_h,
                   dlo: in_pos_z, dhi: in_depth_high, solid: in_is_solid,
                   unsafe: in_is_unsafe};
  assign shift_en = (state_r == ST_WALK);

  // Ring: cell 0 feeds the evaluator and moves to the far end each cycle while walking.
  for (genvar g = 0; g < MAX_COLLIDERS; g++) begin : g_ring
    acr_cell u_cell (
      .clk(clk),
      .wr_en(accept && mode_t'(in_mode) == MODE_WRITE && 32'(in_slot) == g),
      .wr_data(wdata),
      .shift_en(shift_en),
      .shift_in(cells[(g + 1) % MAX_COLLIDERS]),
      .coll_q(cells[g])
    );
  end

  acr_eval u_eval (
    .mode(mode_r),
    .c(cells[0]),
    .active(idx_r < active_n),
    .b(body_r),
    .b_nxt(eval_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      idx_r <= '0;
      pass_r <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      pass_r <= pass_nxt;
      if (cfg_valid && cfg_ready) count_r <= cfg_collider_count;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) mode_r <= mode_t'(in_mode);
    body_r <= body_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    pass_nxt = pass_r;
    body_nxt = body_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          body_nxt.x = CW'(in_pos_x);
          body_nxt.y = CW'(in_pos_y);
          body_nxt.z = CW'(in_pos_z);
          body_nxt.h = CW'({1'b0, in_size_h});
          body_nxt.lo = CW'(in_pos_x) - CW'({1'b0, in_size_w});
          body_nxt.hi = CW'(in_pos_x) + CW'({1'b0, in_size_w});
          body_nxt.prev = CW'(in_pos_y);
          if (mode_t'(in_mode) == MODE_VERT) body_nxt.prev = CW'(in_prev_bottom);
          body_nxt.moved = 1'b0;
          body_nxt.landed = 1'b0;
          body_nxt.hit = 1'b0;
          idx_nxt = '0;
          pass_nxt = '0;
          state_nxt = (mode_t'(in_mode) == MODE_WRITE) ? ST_DONE : ST_WALK;
        end
      end
      ST_WALK: begin
        body_nxt = eval_out;
        if (idx_r == IW'(MAX_COLLIDERS - 1)) begin
          idx_nxt = '0;
          if (mode_r == MODE_HORIZ && eval_out.moved && pass_r != PW'(PUSH_PASSES - 1)) begin
            // New pass: edges resampled from the pushed x, half width kept.
            pass_nxt = pass_r + 1'b1;
            body_nxt.moved = 1'b0;
            body_nxt.lo = eval_out.x - ((body_r.hi - body_r.lo) >>> 1);
            body_nxt.hi = eval_out.x + ((body_r.hi - body_r.lo) >>> 1);
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    res = (mode_r == MODE_VERT) ? body_r.y : body_r.x;
    out_valid = (state_r == ST_DONE);
    out_resolved_pos = '0;
    out_landed = 1'b0;
    out_unsafe_hit = 1'b0;
    if (mode_r == MODE_HORIZ || mode_r == MODE_VERT) begin
      if (res > CW'(64'sd2147483647)) out_resolved_pos = 32'h7fffffff;
      else if (res < CW'(-64'sd2147483648)) out_resolved_pos = 32'h80000000;
      else out_resolved_pos = res[31:0];
    end
    if (mode_r == MODE_VERT) out_landed = body_r.landed;
    if (mode_r == MODE_UNSAFE) out_unsafe_hit = body_r.hit;
  end

`include "assert_macros.svh"
  `ACR_ASSERT_IMPL(a_done_idle, out_valid, !busy)
  `ACR_ASSERT_IMPL(a_accept_busy, accept, busy)
  `ACR_ASSERT_NEVER(a_pass_range, pass_r > PW'(PUSH_PASSES - 1))
endmodule
